FILE: rtl/pdll_pkg.sv
// ----------------------------------------------------------------------------
// pdll_pkg: shared types and constants of the positional linked list
// Node pool size, link and index widths, action and status codes, and the
// request and data groups passed between the sequencer and the top level.
// ----------------------------------------------------------------------------
package pdll_pkg;

  // Number of nodes in the pool.
  localparam int POOL_NODES = 16;

  // A node index addresses the pool; a link also holds the null marker.
  localparam int IDX_W  = $clog2(POOL_NODES);
  localparam int LINK_W = $clog2(POOL_NODES + 1);
  // Counters run from zero up to POOL_NODES.
  localparam int CNT_W  = LINK_W;

  // Fixed field widths of the channels.
  localparam int ACT_W  = 2;
  localparam int POS_W  = 5;
  localparam int CHAR_W = 8;
  localparam int STAT_W = 2;

  // Compare width for a position against the list length.
  localparam int CMP_W = (POS_W > CNT_W) ? POS_W : CNT_W;

  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(POOL_NODES);

  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT   = 2'd0,
    ACT_DELETE   = 2'd1,
    ACT_LIST_FWD = 2'd2,
    ACT_LIST_REV = 2'd3
  } action_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  // One accepted input item.
  typedef struct packed {
    action_e             action;
    logic [POS_W-1:0]    position;
    logic [CHAR_W-1:0]   in_char;
  } cmd_t;

  // Registered read data of the three node stores at one address.
  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic [LINK_W-1:0] next;
    logic [LINK_W-1:0] prev;
  } node_rd_t;

  // Write request to a link store.
  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  addr;
    logic [LINK_W-1:0] data;
  } link_wr_t;

  // Write request to the character store.
  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  addr;
    logic [CHAR_W-1:0] data;
  } char_wr_t;

  // Result item handed to the output register.
  typedef struct packed {
    logic              valid;
    logic [CHAR_W-1:0] out_char;
    logic              carries_char;
    status_e           status;
    logic              last;
  } emit_t;

  // True when a link points at a real node rather than the null marker.
  function automatic logic is_node(logic [LINK_W-1:0] l);
    return l < LINK_W'(POOL_NODES);
  endfunction

  // Memory address of a link.
  function automatic logic [IDX_W-1:0] idx_of(logic [LINK_W-1:0] l);
    return l[IDX_W-1:0];
  endfunction

endpackage

FILE: rtl/pdll_if.sv
// ----------------------------------------------------------------------------
// pdll_if: channel interfaces of the positional linked list
// The command channel carries one action per item; the result channel
// carries one listed character or status per item.
// ----------------------------------------------------------------------------
interface pdll_in_if;
  import pdll_pkg::*;

  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  action;
  logic [POS_W-1:0]  position;
  logic [CHAR_W-1:0] in_char;

  modport source (output valid, output action, output position, output in_char,
                  input ready);
  modport sink   (input valid, input action, input position, input in_char,
                  output ready);
endinterface

interface pdll_out_if;
  import pdll_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] out_char;
  logic              carries_char;
  logic [STAT_W-1:0] status;
  logic              last;

  modport source (output valid, output out_char, output carries_char,
                  output status, output last, input ready);
  modport sink   (input valid, input out_char, input carries_char,
                  input status, input last, output ready);
endinterface

FILE: rtl/pdll_ram.sv
// ----------------------------------------------------------------------------
// pdll_ram: generic single-write, single-read memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pdll_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Storage array and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: rtl/pdll_seq.sv
// ----------------------------------------------------------------------------
// pdll_seq: list sequencer and link walker
// Holds head, tail, length and allocation count, walks the links one node
// per cycle through the shared read port, and issues the link updates.
// ----------------------------------------------------------------------------
module pdll_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  pdll_pkg::cmd_t      cmd_i,
  input  logic                out_free_i,
  output logic [pdll_pkg::IDX_W-1:0] rd_addr_o,
  input  pdll_pkg::node_rd_t  node_rd_i,
  output pdll_pkg::char_wr_t  char_wr_o,
  output pdll_pkg::link_wr_t  next_wr_o,
  output pdll_pkg::link_wr_t  prev_wr_o,
  output pdll_pkg::emit_t     emit_o
);
  import pdll_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_WALK     = 7'b0000010,
    S_INS_LINK = 7'b0000100,
    S_APPEND   = 7'b0001000,
    S_APP_LINK = 7'b0010000,
    S_LIST     = 7'b0100000,
    S_RESP     = 7'b1000000
  } state_e;

  state_e            state_q, state_d;
  logic [LINK_W-1:0] head_q, head_d;
  logic [LINK_W-1:0] tail_q, tail_d;
  logic [CNT_W-1:0]  len_q, len_d;
  logic [CNT_W-1:0]  alloc_q, alloc_d;

  action_e           op_q, op_d;
  logic [CHAR_W-1:0] char_q, char_d;
  logic [LINK_W-1:0] cur_q, cur_d;
  logic [LINK_W-1:0] before_q, before_d;
  logic [CNT_W-1:0]  steps_q, steps_d;
  status_e           status_q, status_d;

  logic [CMP_W-1:0]  pos_x;
  logic [CMP_W-1:0]  len_x;
  logic [LINK_W-1:0] start_link;
  logic [LINK_W-1:0] fresh;
  logic [LINK_W-1:0] list_link;
  logic              list_last;

  assign pos_x      = CMP_W'(cmd_i.position);
  assign len_x      = CMP_W'(len_q);
  assign start_link = (cmd_i.action == ACT_LIST_REV) ? tail_q : head_q;
  assign fresh      = LINK_W'(alloc_q);
  assign list_link  = (op_q == ACT_LIST_REV) ? node_rd_i.prev : node_rd_i.next;
  assign list_last  = (steps_q == CNT_W'(1)) || !is_node(list_link);
  assign in_ready_o = (state_q == S_IDLE);

  // Sequencer: dispatch, link walk, link updates and result hand-off.
  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    tail_d    = tail_q;
    len_d     = len_q;
    alloc_d   = alloc_q;
    op_d      = op_q;
    char_d    = char_q;
    cur_d     = cur_q;
    before_d  = before_q;
    steps_d   = steps_q;
    status_d  = status_q;
    rd_addr_o = idx_of(cur_q);
    char_wr_o = '0;
    next_wr_o = '0;
    prev_wr_o = '0;
    emit_o    = '0;

    unique case (state_q)
      S_IDLE: begin
        // Keep the start node read so its data is ready on the next cycle.
        rd_addr_o = idx_of(start_link);
        if (in_valid_i) begin
          op_d   = cmd_i.action;
          char_d = cmd_i.in_char;
          cur_d  = start_link;
          unique case (cmd_i.action)
            ACT_INSERT: begin
              if (pos_x > len_x) begin
                status_d = ST_RANGE;
                state_d  = S_RESP;
              end else if (alloc_q >= CNT_W'(POOL_NODES)) begin
                status_d = ST_FULL;
                state_d  = S_RESP;
              end else if (pos_x == len_x) begin
                state_d = S_APPEND;
              end else begin
                steps_d = CNT_W'(cmd_i.position);
                state_d = S_WALK;
              end
            end
            ACT_DELETE: begin
              if (len_q == '0) begin
                status_d = ST_EMPTY;
                state_d  = S_RESP;
              end else if (pos_x >= len_x) begin
                status_d = ST_RANGE;
                state_d  = S_RESP;
              end else begin
                steps_d = CNT_W'(cmd_i.position);
                state_d = S_WALK;
              end
            end
            ACT_LIST_FWD, ACT_LIST_REV: begin
              if (len_q == '0) begin
                status_d = ST_EMPTY;
                state_d  = S_RESP;
              end else begin
                steps_d = len_q;
                state_d = S_LIST;
              end
            end
            default: state_d = S_IDLE;
          endcase
        end
      end

      S_WALK: begin
        // The read data belongs to the node in cur_q.
        if (!is_node(cur_q)) begin
          status_d = ST_RANGE;
          state_d  = S_RESP;
        end else if (steps_q == '0) begin
          if (op_q == ACT_INSERT) begin
            // Fresh node goes between the previous node and this one.
            char_wr_o = '{we: 1'b1, addr: idx_of(fresh), data: char_q};
            prev_wr_o = '{we: 1'b1, addr: idx_of(fresh), data: node_rd_i.prev};
            next_wr_o = '{we: 1'b1, addr: idx_of(fresh), data: cur_q};
            before_d  = node_rd_i.prev;
            state_d   = S_INS_LINK;
          end else begin
            // Unlink this node from its neighbors.
            if (is_node(node_rd_i.prev)) begin
              next_wr_o = '{we: 1'b1, addr: idx_of(node_rd_i.prev),
                            data: node_rd_i.next};
            end else begin
              head_d = node_rd_i.next;
            end
            if (is_node(node_rd_i.next)) begin
              prev_wr_o = '{we: 1'b1, addr: idx_of(node_rd_i.next),
                            data: node_rd_i.prev};
            end else begin
              tail_d = node_rd_i.prev;
            end
            len_d    = len_q - CNT_W'(1);
            status_d = ST_OK;
            state_d  = S_RESP;
          end
        end else begin
          cur_d     = node_rd_i.next;
          steps_d   = steps_q - CNT_W'(1);
          rd_addr_o = idx_of(node_rd_i.next);
        end
      end

      S_INS_LINK: begin
        prev_wr_o = '{we: 1'b1, addr: idx_of(cur_q), data: fresh};
        if (is_node(before_q)) begin
          next_wr_o = '{we: 1'b1, addr: idx_of(before_q), data: fresh};
        end else begin
          head_d = fresh;
        end
        alloc_d  = alloc_q + CNT_W'(1);
        len_d    = len_q + CNT_W'(1);
        status_d = ST_OK;
        state_d  = S_RESP;
      end

      S_APPEND: begin
        char_wr_o = '{we: 1'b1, addr: idx_of(fresh), data: char_q};
        prev_wr_o = '{we: 1'b1, addr: idx_of(fresh), data: tail_q};
        next_wr_o = '{we: 1'b1, addr: idx_of(fresh), data: NULL_LINK};
        state_d   = S_APP_LINK;
      end

      S_APP_LINK: begin
        if (is_node(tail_q)) begin
          next_wr_o = '{we: 1'b1, addr: idx_of(tail_q), data: fresh};
        end else begin
          head_d = fresh;
        end
        tail_d   = fresh;
        alloc_d  = alloc_q + CNT_W'(1);
        len_d    = len_q + CNT_W'(1);
        status_d = ST_OK;
        state_d  = S_RESP;
      end

      S_LIST: begin
        // One entry per cycle while the output register can take it.
        if (out_free_i) begin
          emit_o = '{valid: 1'b1, out_char: node_rd_i.ch, carries_char: 1'b1,
                     status: ST_OK, last: list_last};
          if (list_last) begin
            state_d = S_IDLE;
          end else begin
            cur_d     = list_link;
            steps_d   = steps_q - CNT_W'(1);
            rd_addr_o = idx_of(list_link);
          end
        end
      end

      S_RESP: begin
        if (out_free_i) begin
          emit_o  = '{valid: 1'b1, out_char: '0, carries_char: 1'b0,
                      status: status_q, last: 1'b1};
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Control state: empty list after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= NULL_LINK;
      tail_q  <= NULL_LINK;
      len_q   <= '0;
      alloc_q <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      len_q   <= len_d;
      alloc_q <= alloc_d;
    end
  end

  // Working registers of the item in flight.
  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    char_q   <= char_d;
    cur_q    <= cur_d;
    before_q <= before_d;
    steps_q  <= steps_d;
    status_q <= status_d;
  end

endmodule

FILE: rtl/positional_doubly_linked_list.sv
// ----------------------------------------------------------------------------
// positional_doubly_linked_list: doubly linked character list in a node pool
// Insert, delete, forward listing and reverse listing over a fixed pool of
// nodes held in three small memories, with a registered result stage.
// ----------------------------------------------------------------------------
// An insert at p walks to its node, writes the fresh node, then links the
// neighbors (an append skips the walk); a delete walks to p and unlinks the
// node; an error status goes straight to the result stage. A listing gives
// one entry per cycle while the output register can take it; the walk
// follows one link per cycle. A new item is accepted once the previous one's
// last result is handed on. Reset empties the list; memories are not cleared.
module positional_doubly_linked_list (
  input  logic           clk_i,
  input  logic           rst_ni,
  pdll_in_if.sink        in_i,
  pdll_out_if.source     out_o
);
  import pdll_pkg::*;

  cmd_t              cmd;
  node_rd_t          node_rd;
  char_wr_t          char_wr;
  link_wr_t          next_wr;
  link_wr_t          prev_wr;
  emit_t             emit;
  logic [IDX_W-1:0]  rd_addr;
  logic              out_free;

  logic              out_valid_q;
  logic [CHAR_W-1:0] out_char_q;
  logic              out_carries_q;
  status_e           out_status_q;
  logic              out_last_q;

  assign cmd.action   = action_e'(in_i.action);
  assign cmd.position = in_i.position;
  assign cmd.in_char  = in_i.in_char;

  // The output register can take a result when empty or being drained.
  assign out_free = !out_valid_q || out_o.ready;

  pdll_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .cmd_i      (cmd),
    .out_free_i (out_free),
    .rd_addr_o  (rd_addr),
    .node_rd_i  (node_rd),
    .char_wr_o  (char_wr),
    .next_wr_o  (next_wr),
    .prev_wr_o  (prev_wr),
    .emit_o     (emit)
  );

  // Node stores, all read at the same address.
  pdll_ram #(.WIDTH(CHAR_W), .DEPTH(POOL_NODES)) u_char_ram (
    .clk_i   (clk_i),
    .we_i    (char_wr.we),
    .waddr_i (char_wr.addr),
    .wdata_i (char_wr.data),
    .raddr_i (rd_addr),
    .rdata_o (node_rd.ch)
  );

  pdll_ram #(.WIDTH(LINK_W), .DEPTH(POOL_NODES)) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (next_wr.we),
    .waddr_i (next_wr.addr),
    .wdata_i (next_wr.data),
    .raddr_i (rd_addr),
    .rdata_o (node_rd.next)
  );

  pdll_ram #(.WIDTH(LINK_W), .DEPTH(POOL_NODES)) u_prev_ram (
    .clk_i   (clk_i),
    .we_i    (prev_wr.we),
    .waddr_i (prev_wr.addr),
    .wdata_i (prev_wr.data),
    .raddr_i (rd_addr),
    .rdata_o (node_rd.prev)
  );

  // Output register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit.valid) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (emit.valid) begin
      out_char_q    <= emit.out_char;
      out_carries_q <= emit.carries_char;
      out_status_q  <= emit.status;
      out_last_q    <= emit.last;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.out_char     = out_char_q;
  assign out_o.carries_char = out_carries_q;
  assign out_o.status       = out_status_q;
  assign out_o.last         = out_last_q;

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench of the positional doubly linked list
// Directed items cover the empty list, inserts and deletes at both ends,
// out-of-range positions and an exhausted pool, and random traffic follows.
// A shadow copy of the list predicts every result item, and a checker
// compares each accepted result with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module tb_top;
  import pdll_pkg::*;

  // One predicted result item.
  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              carries;
    status_e           st;
    logic              last;
  } list_reply_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  pdll_in_if  cmd_bus ();
  pdll_out_if rsp_bus ();

  positional_doubly_linked_list DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_bus),
    .out_o  (rsp_bus)
  );

  // Shadow copy of the node pool and list bookkeeping.
  logic [CHAR_W-1:0] shadow_char [POOL_NODES];
  logic [LINK_W-1:0] shadow_next [POOL_NODES];
  logic [LINK_W-1:0] shadow_prev [POOL_NODES];
  logic [LINK_W-1:0] shadow_head;
  logic [LINK_W-1:0] shadow_tail;
  int                shadow_len;
  int                shadow_alloc;

  list_reply_t pending_replies [$];

  int  err_count       = 0;
  int  replies_checked = 0;
  int  items_sent      = 0;
  int  action_count [4];
  int  hold_cycles     = 0;
  logic calm_phase     = 1'b0;

  // Free-running clock, period 12 ns.
  always #6 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Shadow list
  // ---------------------------------------------------------------------------

  function automatic logic live_link(logic [LINK_W-1:0] l);
    return l < NULL_LINK;
  endfunction

  function automatic void clear_shadow();
    for (int i = 0; i < POOL_NODES; i++) begin
      shadow_char[i] = '0;
      shadow_next[i] = '0;
      shadow_prev[i] = '0;
    end
    shadow_head  = NULL_LINK;
    shadow_tail  = NULL_LINK;
    shadow_len   = 0;
    shadow_alloc = 0;
  endfunction

  // Follows next links from the head for pos steps or until the null marker.
  function automatic logic [LINK_W-1:0] node_at(int pos);
    logic [LINK_W-1:0] cur;
    cur = shadow_head;
    for (int i = 0; i < pos && live_link(cur); i++)
      cur = shadow_next[cur[IDX_W-1:0]];
    return cur;
  endfunction

  function automatic status_e shadow_insert(int pos, logic [CHAR_W-1:0] ch);
    logic [LINK_W-1:0] fresh, at, prior;
    if (pos > shadow_len) return ST_RANGE;
    if (shadow_alloc >= POOL_NODES) return ST_FULL;
    fresh = LINK_W'(shadow_alloc);
    shadow_char[fresh[IDX_W-1:0]] = ch;
    if (pos == shadow_len) begin
      // Append behind the current tail.
      shadow_prev[fresh[IDX_W-1:0]] = shadow_tail;
      shadow_next[fresh[IDX_W-1:0]] = NULL_LINK;
      if (live_link(shadow_tail)) shadow_next[shadow_tail[IDX_W-1:0]] = fresh;
      else shadow_head = fresh;
      shadow_tail = fresh;
    end else begin
      // Splice in front of the node now at pos.
      at = node_at(pos);
      if (!live_link(at)) return ST_RANGE;
      prior = shadow_prev[at[IDX_W-1:0]];
      shadow_prev[fresh[IDX_W-1:0]] = prior;
      shadow_next[fresh[IDX_W-1:0]] = at;
      shadow_prev[at[IDX_W-1:0]] = fresh;
      if (live_link(prior)) shadow_next[prior[IDX_W-1:0]] = fresh;
      else shadow_head = fresh;
    end
    shadow_alloc++;
    shadow_len++;
    return ST_OK;
  endfunction

  function automatic status_e shadow_delete(int pos);
    logic [LINK_W-1:0] at, prior, later;
    if (shadow_len == 0) return ST_EMPTY;
    if (pos >= shadow_len) return ST_RANGE;
    at = node_at(pos);
    if (!live_link(at)) return ST_RANGE;
    prior = shadow_prev[at[IDX_W-1:0]];
    later = shadow_next[at[IDX_W-1:0]];
    if (live_link(prior)) shadow_next[prior[IDX_W-1:0]] = later;
    else shadow_head = later;
    if (live_link(later)) shadow_prev[later[IDX_W-1:0]] = prior;
    else shadow_tail = prior;
    shadow_len--;
    return ST_OK;
  endfunction

  function automatic void push_status(status_e s);
    pending_replies.push_back('{ch: '0, carries: 1'b0, st: s, last: 1'b1});
  endfunction

  // Predicts a full listing; last marks the entry after which the walk stops.
  function automatic void expect_listing(logic reverse);
    logic [LINK_W-1:0] cur, step_to;
    logic              done;
    int                k;
    if (shadow_len == 0) begin
      push_status(ST_EMPTY);
      return;
    end
    cur = reverse ? shadow_tail : shadow_head;
    k = 0;
    while (live_link(cur) && k < shadow_len && k < POOL_NODES) begin
      step_to = reverse ? shadow_prev[cur[IDX_W-1:0]] : shadow_next[cur[IDX_W-1:0]];
      done = !(live_link(step_to) && (k + 1) < shadow_len && (k + 1) < POOL_NODES);
      pending_replies.push_back('{ch: shadow_char[cur[IDX_W-1:0]], carries: 1'b1,
                                  st: ST_OK, last: done});
      k++;
      cur = step_to;
    end
    if (k == 0) push_status(ST_EMPTY);
  endfunction

  function automatic void predict_command(action_e act, logic [POS_W-1:0] pos,
                                          logic [CHAR_W-1:0] ch);
    case (act)
      ACT_INSERT:   push_status(shadow_insert(int'(pos), ch));
      ACT_DELETE:   push_status(shadow_delete(int'(pos)));
      ACT_LIST_FWD: expect_listing(1'b0);
      default:      expect_listing(1'b1);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Offers one command item, with a random gap unless traffic is calm.
  task automatic send_command(input action_e act, input logic [POS_W-1:0] pos,
                              input logic [CHAR_W-1:0] ch);
    int gap;
    gap = 0;
    if (!calm_phase && $urandom_range(99) < 30) gap = $urandom_range(6, 1);
    repeat (gap) @(negedge clk_i);
    @(negedge clk_i);
    cmd_bus.valid    = 1'b1;
    cmd_bus.action   = act;
    cmd_bus.position = pos;
    cmd_bus.in_char  = ch;
    do @(posedge clk_i); while (!cmd_bus.ready);
    predict_command(act, pos, ch);
    items_sent++;
    action_count[int'(act)]++;
    @(negedge clk_i);
    cmd_bus.valid = 1'b0;
  endtask

  task automatic wait_replies_drained();
    while (pending_replies.size() != 0) @(posedge clk_i);
  endtask

  // Result ready: long hold when requested, otherwise random or always high.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      rsp_bus.ready = 1'b0;
    end else if (hold_cycles > 0) begin
      rsp_bus.ready = 1'b0;
      hold_cycles--;
    end else if (calm_phase) begin
      rsp_bus.ready = 1'b1;
    end else begin
      rsp_bus.ready = ($urandom_range(99) >= 30);
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_replies
    list_reply_t want;
    if (rst_ni && rsp_bus.valid && rsp_bus.ready) begin
      if (pending_replies.size() == 0) begin
        $display("%0t ns: unexpected result item, expected none, actual char %02h status %0d",
                 $time, rsp_bus.out_char, rsp_bus.status);
        err_count++;
      end else begin
        want = pending_replies.pop_front();
        replies_checked++;
        if (rsp_bus.out_char !== want.ch) begin
          $display("%0t ns: out_char mismatch, expected %02h, actual %02h",
                   $time, want.ch, rsp_bus.out_char);
          err_count++;
        end
        if (rsp_bus.carries_char !== want.carries) begin
          $display("%0t ns: carries_char mismatch, expected %0b, actual %0b",
                   $time, want.carries, rsp_bus.carries_char);
          err_count++;
        end
        if (rsp_bus.status !== want.st) begin
          $display("%0t ns: status mismatch, expected %0d, actual %0d",
                   $time, want.st, rsp_bus.status);
          err_count++;
        end
        if (rsp_bus.last !== want.last) begin
          $display("%0t ns: last mismatch, expected %0b, actual %0b",
                   $time, want.last, rsp_bus.last);
          err_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Listing and deleting on the empty list, and inserts past its end.
  task automatic test_empty_list();
    send_command(ACT_LIST_FWD, 5'd0, 8'h00);
    send_command(ACT_LIST_REV, 5'd0, 8'h00);
    send_command(ACT_DELETE, 5'd0, 8'h00);
    send_command(ACT_DELETE, 5'd31, 8'hFF);
    send_command(ACT_INSERT, 5'd1, 8'h41);
    send_command(ACT_INSERT, 5'd31, 8'hFF);
  endtask

  // Inserts into the empty list, at the tail, at the head and in the middle.
  task automatic test_insert_ends();
    send_command(ACT_INSERT, 5'd0, 8'h00);
    send_command(ACT_INSERT, 5'd1, 8'hFF);
    send_command(ACT_INSERT, 5'd0, 8'h80);
    send_command(ACT_INSERT, 5'd1, 8'h7F);
    send_command(ACT_LIST_FWD, 5'd0, 8'h00);
    send_command(ACT_LIST_REV, 5'd0, 8'h00);
  endtask

  // Delete at the length, at the head and at the tail, then refill.
  task automatic test_delete_ends();
    send_command(ACT_DELETE, 5'd4, 8'h00);
    send_command(ACT_DELETE, 5'd0, 8'h00);
    send_command(ACT_DELETE, 5'd2, 8'h00);
    send_command(ACT_LIST_FWD, 5'd0, 8'h00);
    send_command(ACT_LIST_REV, 5'd0, 8'h00);
    send_command(ACT_INSERT, 5'd2, 8'h55);
    send_command(ACT_INSERT, 5'd1, 8'hAA);
    send_command(ACT_LIST_FWD, 5'd0, 8'h00);
  endtask

  // The receiver stalls for a long stretch while commands keep coming.
  task automatic test_receiver_backlog();
    wait_replies_drained();
    hold_cycles = 320;
    send_command(ACT_LIST_FWD, 5'd0, 8'h00);
    send_command(ACT_LIST_REV, 5'd0, 8'h00);
    send_command(ACT_INSERT, POS_W'($urandom_range(shadow_len, 0)),
                 CHAR_W'($urandom_range(255, 0)));
    send_command(ACT_LIST_FWD, 5'd0, 8'h00);
    send_command(ACT_DELETE, 5'd31, 8'h00);
    send_command(ACT_LIST_REV, 5'd0, 8'h00);
  endtask

  // Mixed random commands; most insert positions are in range, most delete positions are random noise.
  task automatic test_random_traffic(input int count);
    int      roll;
    int      pos;
    action_e act;
    for (int n = 0; n < count; n++) begin
      calm_phase = (n >= count / 3) && (n < count / 3 + 50);
      roll = $urandom_range(99);
      if (roll < 25) begin
        act = ACT_INSERT;
        if ($urandom_range(99) < 75) pos = $urandom_range(shadow_len, 0);
        else pos = $urandom_range(31, 0);
      end else if (roll < 40) begin
        act = ACT_DELETE;
        if (shadow_len > 0 && $urandom_range(99) < 30) pos = $urandom_range(shadow_len - 1, 0);
        else pos = $urandom_range(31, 0);
      end else begin
        act = (roll < 70) ? ACT_LIST_FWD : ACT_LIST_REV;
        pos = $urandom_range(31, 0);
      end
      send_command(act, POS_W'(pos), CHAR_W'($urandom_range(255, 0)));
    end
    calm_phase = 1'b0;
  endtask

  // The sender stops until every predicted result has arrived.
  task automatic test_sender_pause();
    send_command(ACT_LIST_FWD, 5'd0, 8'h00);
    send_command(ACT_DELETE, POS_W'($urandom_range(31, 0)), 8'h00);
    send_command(ACT_LIST_REV, 5'd0, 8'h00);
    wait_replies_drained();
    send_command(ACT_LIST_REV, 5'd0, 8'h00);
    send_command(ACT_INSERT, POS_W'($urandom_range(shadow_len, 0)),
                 CHAR_W'($urandom_range(255, 0)));
    send_command(ACT_LIST_FWD, 5'd0, 8'h00);
  endtask

  // Uses up the pool, checks the full case, then drains the list to empty.
  task automatic test_pool_exhausted();
    while (shadow_alloc < POOL_NODES)
      send_command(ACT_INSERT, POS_W'($urandom_range(shadow_len, 0)),
                   CHAR_W'($urandom_range(255, 0)));
    send_command(ACT_INSERT, 5'd0, 8'h5A);
    send_command(ACT_INSERT, POS_W'(shadow_len + 1), 8'hA5);
    send_command(ACT_LIST_REV, 5'd0, 8'h00);
    while (shadow_len > 0) begin
      send_command(ACT_DELETE, POS_W'($urandom_range(shadow_len - 1, 0)), 8'h00);
      if ($urandom_range(99) < 30) send_command(ACT_LIST_FWD, 5'd0, 8'h00);
    end
    send_command(ACT_LIST_FWD, 5'd0, 8'h00);
    send_command(ACT_LIST_REV, 5'd0, 8'h00);
    send_command(ACT_DELETE, 5'd0, 8'h00);
    send_command(ACT_INSERT, 5'd0, 8'hFF);
    send_command(ACT_INSERT, 5'd1, 8'h00);
  endtask

  // ---------------------------------------------------------------------------
  // Sequence of the run
  // ---------------------------------------------------------------------------
  initial begin
    cmd_bus.valid    = 1'b0;
    cmd_bus.action   = ACT_INSERT;
    cmd_bus.position = '0;
    cmd_bus.in_char  = '0;
    rsp_bus.ready    = 1'b0;
    for (int i = 0; i < 4; i++) action_count[i] = 0;
    clear_shadow();

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_empty_list();
    test_insert_ends();
    test_delete_ends();
    test_receiver_backlog();
    test_random_traffic(160);
    test_sender_pause();
    test_random_traffic(160);
    test_pool_exhausted();

    wait_replies_drained();
    repeat (30) @(posedge clk_i);

    $display("Run covered %0d commands: %0d inserts, %0d deletes, %0d forward and %0d reverse listings.",
             items_sent, action_count[0], action_count[1], action_count[2], action_count[3]);
    $display("%0d result items checked, pool use %0d of %0d nodes, %0d mismatches.",
             replies_checked, shadow_alloc, POOL_NODES, err_count);
    if (err_count == 0) begin
      $display("** positional_doubly_linked_list: PASSED **");
    end else begin
      $display("** positional_doubly_linked_list: FAILED **");
    end
    $finish;
  end

  // Hard limit on the run time.
  initial begin
    #5_000_000;
    $display("Timeout with %0d result items still expected.", pending_replies.size());
    $display("** positional_doubly_linked_list: FAILED **");
    $finish;
  end

endmodule
